// File: hdl/hilbert_curve_index_convert_defines.svh
// Assertion macros for the Hilbert curve index converter.
`ifndef HILBERT_CURVE_INDEX_CONVERT_DEFINES_SVH
`define HILBERT_CURVE_INDEX_CONVERT_DEFINES_SVH

// Same-cycle implication, muted while reset is asserted.
`define HCIC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted while reset is asserted.
`define HCIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/hcic_pkg.sv
// Shared constants for the Hilbert curve index converter.
package hcic_pkg;

    localparam int XY_W    = 8;   // coordinate field width
    localparam int IDX_W   = 16;  // curve index field width
    localparam int ORDER_W = 4;   // curve order register width
    localparam int DATA_W  = 2 * XY_W + IDX_W;

    localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(4);

    typedef enum logic {
        REQ_XY_TO_IDX = 1'b0,
        REQ_IDX_TO_XY = 1'b1
    } t_req;

endpackage

// File: hdl/hcic_level.sv
// One pipelined level of the Hilbert curve conversion, both directions.
module hcic_level import hcic_pkg::*; #(
    parameter int MAX_ORDER = 8,
    parameter int LEVEL     = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // upstream side
    input  logic                         i_valid,
    output logic                         o_ready,
    input  t_req                         i_type,
    input  logic [$clog2(MAX_ORDER+1)-1:0] i_k,
    input  logic [MAX_ORDER-1:0]         i_x,
    input  logic [MAX_ORDER-1:0]         i_y,
    input  logic [2*MAX_ORDER-1:0]       i_d,
    // downstream side
    output logic                         o_valid,
    input  logic                         i_ready,
    output t_req                         o_type,
    output logic [$clog2(MAX_ORDER+1)-1:0] o_k,
    output logic [MAX_ORDER-1:0]         o_x,
    output logic [MAX_ORDER-1:0]         o_y,
    output logic [2*MAX_ORDER-1:0]       o_d
);

    localparam int KW = $clog2(MAX_ORDER + 1);
    // xy->d walks from the top bit down, d->xy from the bottom up
    localparam int C2I_BIT = MAX_ORDER - 1 - LEVEL;
    localparam logic [KW-1:0] C2I_FROM = KW'(MAX_ORDER - LEVEL);
    localparam logic [KW-1:0] I2C_LVL  = KW'(LEVEL);
    localparam logic [MAX_ORDER-1:0] LOW_MASK = {MAX_ORDER{1'b1}} >> (MAX_ORDER - LEVEL);

    logic                   r_valid;
    t_req                   r_type;
    logic [KW-1:0]          r_k;
    logic [MAX_ORDER-1:0]   r_x, r_y;
    logic [2*MAX_ORDER-1:0] r_d;

    logic [MAX_ORDER-1:0]   n_x, n_y;
    logic [2*MAX_ORDER-1:0] n_d;
    logic                   rx, ry;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_x = i_x;
        n_y = i_y;
        n_d = i_d;
        rx  = 1'b0;
        ry  = 1'b0;
        case (i_type)
            REQ_XY_TO_IDX: begin
                if (i_k >= C2I_FROM) begin
                    rx = i_x[C2I_BIT];
                    ry = i_y[C2I_BIT];
                    n_d[2*C2I_BIT +: 2] = {rx, rx ^ ry};
                    if (!ry) begin
                        // stale upper bits are never read again
                        n_x = rx ? ~i_y : i_y;
                        n_y = rx ? ~i_x : i_x;
                    end
                end
            end
            REQ_IDX_TO_XY: begin
                if (i_k > I2C_LVL) begin
                    rx = i_d[2*LEVEL+1];
                    ry = i_d[2*LEVEL] ^ rx;
                    if (!ry) begin
                        n_x = rx ? (~i_y & LOW_MASK) : i_y;
                        n_y = rx ? (~i_x & LOW_MASK) : i_x;
                    end
                    n_x[LEVEL] = rx;
                    n_y[LEVEL] = ry;
                end
            end
            default: begin
                n_x = i_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_type <= i_type;
            r_k    <= i_k;
            r_x    <= n_x;
            r_y    <= n_y;
            r_d    <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_type  = r_type;
    assign o_k     = r_k;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_d     = r_d;

endmodule

// File: hdl/hilbert_curve_index_convert.sv
// Hilbert curve converter top level: point to curve index and back.
//
//  channel   dir  beat contents
//  s_axis    in   tdata: in_x, in_y, in_index   tuser: req_type
//  m_axis    out  tdata: out_x, out_y, out_index
//  cfg       in   i_cfg_we / i_cfg_wdata: curve_order
//
// The pipe holds an input register, one register per curve level,
// and an output register. One beat enters per cycle while the input is not stalled.
// Each level register holds its beat when the next one is full and stalled;
// empty levels keep filling, so the input stalls only with the pipe full.
// Synchronous active-low reset clears the valid bits and sets curve_order to 4.
module hilbert_curve_index_convert import hcic_pkg::*; #(
    parameter int MAX_ORDER = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [ORDER_W-1:0]  i_cfg_wdata,    // curve_order
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [DATA_W-1:0]   s_axis_tdata,   // in_x [7:0], in_y [15:8], in_index [31:16]
    input  logic                s_axis_tuser,   // req_type
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [DATA_W-1:0]   m_axis_tdata    // out_x [7:0], out_y [15:8], out_index [31:16]
);

    `include "hilbert_curve_index_convert_defines.svh"

    localparam int KW = $clog2(MAX_ORDER + 1);
    localparam int DW = 2 * MAX_ORDER;

    logic [ORDER_W-1:0]   r_curve_order;
    logic [KW-1:0]        k_eff;
    logic [MAX_ORDER-1:0] coord_mask;
    logic [DW-1:0]        idx_mask;

    // input stage
    logic                 r_v0;
    t_req                 r_type0;
    logic [KW-1:0]        r_k0;
    logic [MAX_ORDER-1:0] r_x0, r_y0;
    logic [DW-1:0]        r_d0;
    logic                 ready0;
    t_req                 in_type;

    // level chain, entry j feeds level j
    logic [MAX_ORDER:0]   lv_valid, lv_ready;
    t_req                 lv_type [MAX_ORDER+1];
    logic [KW-1:0]        lv_k    [MAX_ORDER+1];
    logic [MAX_ORDER-1:0] lv_x    [MAX_ORDER+1];
    logic [MAX_ORDER-1:0] lv_y    [MAX_ORDER+1];
    logic [DW-1:0]        lv_d    [MAX_ORDER+1];

    // output stage
    logic                 r_ov;
    logic [XY_W-1:0]      r_ox, r_oy;
    logic [IDX_W-1:0]     r_oidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_order <= ORDER_RESET;
        end else if (i_cfg_we) begin
            r_curve_order <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_curve_order == '0) begin
            k_eff = KW'(1);
        end else if (int'(r_curve_order) > MAX_ORDER) begin
            k_eff = KW'(MAX_ORDER);
        end else begin
            k_eff = KW'(r_curve_order);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_ORDER; i++) begin
            coord_mask[i]      = int'(k_eff) > i;
            idx_mask[2*i +: 2] = {2{int'(k_eff) > i}};
        end
    end

    assign in_type       = t_req'(s_axis_tuser);
    assign ready0        = !r_v0 || lv_ready[0];
    assign s_axis_tready = ready0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (ready0) begin
            r_v0 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && ready0) begin
            r_type0 <= in_type;
            r_k0    <= k_eff;
            if (in_type == REQ_XY_TO_IDX) begin
                r_x0 <= MAX_ORDER'(s_axis_tdata[XY_W-1:0]) & coord_mask;
                r_y0 <= MAX_ORDER'(s_axis_tdata[2*XY_W-1:XY_W]) & coord_mask;
                r_d0 <= '0;
            end else begin
                r_x0 <= '0;
                r_y0 <= '0;
                r_d0 <= DW'(s_axis_tdata[DATA_W-1:2*XY_W]) & idx_mask;
            end
        end
    end

    assign lv_valid[0] = r_v0;
    assign lv_type[0]  = r_type0;
    assign lv_k[0]     = r_k0;
    assign lv_x[0]     = r_x0;
    assign lv_y[0]     = r_y0;
    assign lv_d[0]     = r_d0;

    for (genvar j = 0; j < MAX_ORDER; j++) begin : g_level
        hcic_level #(
            .MAX_ORDER (MAX_ORDER),
            .LEVEL     (j)
        ) u_level (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (lv_valid[j]),
            .o_ready (lv_ready[j]),
            .i_type  (lv_type[j]),
            .i_k     (lv_k[j]),
            .i_x     (lv_x[j]),
            .i_y     (lv_y[j]),
            .i_d     (lv_d[j]),
            .o_valid (lv_valid[j+1]),
            .i_ready (lv_ready[j+1]),
            .o_type  (lv_type[j+1]),
            .o_k     (lv_k[j+1]),
            .o_x     (lv_x[j+1]),
            .o_y     (lv_y[j+1]),
            .o_d     (lv_d[j+1])
        );
    end

    assign lv_ready[MAX_ORDER] = !r_ov || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (lv_ready[MAX_ORDER]) begin
            r_ov <= lv_valid[MAX_ORDER];
        end
    end

    always_ff @(posedge i_clk) begin
        if (lv_valid[MAX_ORDER] && lv_ready[MAX_ORDER]) begin
            if (lv_type[MAX_ORDER] == REQ_IDX_TO_XY) begin
                r_ox   <= XY_W'(lv_x[MAX_ORDER]);
                r_oy   <= XY_W'(lv_y[MAX_ORDER]);
                r_oidx <= '0;
            end else begin
                r_ox   <= '0;
                r_oy   <= '0;
                r_oidx <= IDX_W'(lv_d[MAX_ORDER]);
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_oidx, r_oy, r_ox};

    `HCIC_ASSERT_IMPL(a_one_result_kind, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tdata[2*XY_W-1:0] != '0),
        m_axis_tdata[DATA_W-1:2*XY_W] == '0, "point and index both nonzero in one beat")
    `HCIC_ASSERT_IMPL(a_stall_only_when_full, i_clk, i_rst_n, !s_axis_tready,
        m_axis_tvalid && !m_axis_tready, "input stalled while output is free")
    `HCIC_ASSERT_IMPL(a_order_in_range, i_clk, i_rst_n, 1'b1,
        (k_eff != '0) && (int'(k_eff) <= MAX_ORDER), "effective order out of range")
    `HCIC_ASSERT_NEXT(a_last_level_holds, i_clk, i_rst_n,
        lv_valid[MAX_ORDER] && !lv_ready[MAX_ORDER], lv_valid[MAX_ORDER],
        "last level dropped a stalled beat")

endmodule

// File: bench/tb_hilbert_curve_index_convert.sv
// Self-checking bench for the Hilbert curve converter: directed table, then random phases.
`timescale 1ns / 100ps

module tb_hilbert_curve_index_convert;
    import hcic_pkg::*;

    localparam int          CURVE_MAX_ORDER = 8;
    localparam int          PIPE_LATENCY    = CURVE_MAX_ORDER + 2;
    localparam int          WATCHDOG_LIMIT  = 1000;
    localparam int          HOLD_OFF_CYCLES = 200;
    localparam int          PHASE_COUNT     = 10;
    localparam int          PHASE_BEATS     = 100;
    localparam bit          TYPED           = 1'b1;
    localparam bit          PREDICT         = 1'b0;

    typedef struct packed {
        logic [XY_W-1:0]  px;
        logic [XY_W-1:0]  py;
        logic [IDX_W-1:0] pidx;
    } t_curve_result;

    typedef struct {
        logic [ORDER_W-1:0] order;
        t_req               req;
        logic [XY_W-1:0]    x;
        logic [XY_W-1:0]    y;
        logic [IDX_W-1:0]   idx;
        bit                 typed;
        logic [XY_W-1:0]    want_x;
        logic [XY_W-1:0]    want_y;
        logic [IDX_W-1:0]   want_idx;
    } t_directed_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [ORDER_W-1:0] i_cfg_wdata = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [DATA_W-1:0]  s_axis_tdata = '0;     // in_x [7:0], in_y [15:8], in_index [31:16]
    logic               s_axis_tuser = 1'b0;   // req_type
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [DATA_W-1:0]  m_axis_tdata;          // out_x [7:0], out_y [15:8], out_index [31:16]

    t_curve_result      expected_results[$];
    logic [ORDER_W-1:0] cur_order = ORDER_RESET;
    bit                 sender_burst = 1'b0;
    int unsigned        mismatch_count = 0;
    int unsigned        idle_cycles = 0;

    // order, type, x, y, index, typed?, expected x, y, index
    t_directed_row directed_rows [23] = '{
        '{4'd4,  REQ_XY_TO_IDX, 8'd0,   8'd0,   16'hFFFF, TYPED,   8'd0,   8'd0,   16'd0},
        '{4'd4,  REQ_XY_TO_IDX, 8'd15,  8'd0,   16'h0000, TYPED,   8'd0,   8'd0,   16'd255},
        '{4'd4,  REQ_XY_TO_IDX, 8'd0,   8'd15,  16'h1234, TYPED,   8'd0,   8'd0,   16'd85},
        '{4'd4,  REQ_XY_TO_IDX, 8'd15,  8'd15,  16'h0000, TYPED,   8'd0,   8'd0,   16'd170},
        '{4'd4,  REQ_XY_TO_IDX, 8'd255, 8'd240, 16'hFFFF, TYPED,   8'd0,   8'd0,   16'd255},
        '{4'd4,  REQ_IDX_TO_XY, 8'd255, 8'd255, 16'd0,    TYPED,   8'd0,   8'd0,   16'd0},
        '{4'd4,  REQ_IDX_TO_XY, 8'd0,   8'd0,   16'd255,  TYPED,   8'd15,  8'd0,   16'd0},
        '{4'd4,  REQ_IDX_TO_XY, 8'hAA,  8'h55,  16'hFFFF, TYPED,   8'd15,  8'd0,   16'd0},
        '{4'd4,  REQ_IDX_TO_XY, 8'd0,   8'd0,   16'd170,  TYPED,   8'd15,  8'd15,  16'd0},
        '{4'd4,  REQ_XY_TO_IDX, 8'h5A,  8'hC3,  16'h0F0F, PREDICT, 8'd0,   8'd0,   16'd0},
        '{4'd1,  REQ_XY_TO_IDX, 8'd1,   8'd1,   16'd0,    TYPED,   8'd0,   8'd0,   16'd2},
        '{4'd1,  REQ_IDX_TO_XY, 8'd0,   8'd0,   16'd3,    TYPED,   8'd1,   8'd0,   16'd0},
        '{4'd1,  REQ_IDX_TO_XY, 8'd0,   8'd0,   16'hFFFE, TYPED,   8'd1,   8'd1,   16'd0},
        '{4'd0,  REQ_XY_TO_IDX, 8'd1,   8'd0,   16'd0,    TYPED,   8'd0,   8'd0,   16'd3},
        '{4'd0,  REQ_IDX_TO_XY, 8'd0,   8'd0,   16'd1,    TYPED,   8'd0,   8'd1,   16'd0},
        '{4'd8,  REQ_XY_TO_IDX, 8'd255, 8'd0,   16'd0,    TYPED,   8'd0,   8'd0,   16'd65535},
        '{4'd8,  REQ_XY_TO_IDX, 8'd255, 8'd255, 16'd0,    TYPED,   8'd0,   8'd0,   16'd43690},
        '{4'd8,  REQ_IDX_TO_XY, 8'd0,   8'd0,   16'd65535, TYPED,  8'd255, 8'd0,   16'd0},
        '{4'd8,  REQ_IDX_TO_XY, 8'h3C,  8'h81,  16'hA5C3, PREDICT, 8'd0,   8'd0,   16'd0},
        '{4'd15, REQ_XY_TO_IDX, 8'd0,   8'd255, 16'd0,    TYPED,   8'd0,   8'd0,   16'd21845},
        '{4'd15, REQ_IDX_TO_XY, 8'd0,   8'd0,   16'd43690, TYPED,  8'd255, 8'd255, 16'd0},
        '{4'd5,  REQ_XY_TO_IDX, 8'h1F,  8'h03,  16'h8000, PREDICT, 8'd0,   8'd0,   16'd0},
        '{4'd5,  REQ_IDX_TO_XY, 8'hFF,  8'hFF,  16'h03FF, PREDICT, 8'd0,   8'd0,   16'd0}
    };

    hilbert_curve_index_convert #(
        .MAX_ORDER     (CURVE_MAX_ORDER)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // order 0 acts as 1, anything past the max saturates
    function automatic int unsigned grid_order(input logic [ORDER_W-1:0] order);
        int unsigned k;
        k = 32'(order);
        if (k < 1) k = 1;
        if (k > CURVE_MAX_ORDER) k = CURVE_MAX_ORDER;
        return k;
    endfunction

    function automatic t_curve_result hilbert_predict(input logic [ORDER_W-1:0] order,
                                                      input t_req req,
                                                      input logic [XY_W-1:0] x,
                                                      input logic [XY_W-1:0] y,
                                                      input logic [IDX_W-1:0] idx);
        int unsigned k, n, s, rx, ry, cx, cy, d, t, tmp;
        t_curve_result res;
        k   = grid_order(order);
        n   = 1 << k;
        res = '0;
        if (req == REQ_XY_TO_IDX) begin
            cx = 32'(x) & (n - 1);
            cy = 32'(y) & (n - 1);
            d  = 0;
            for (s = n >> 1; s > 0; s = s >> 1) begin
                rx = ((cx & s) != 0) ? 1 : 0;
                ry = ((cy & s) != 0) ? 1 : 0;
                d  = d + s * s * ((3 * rx) ^ ry);
                // quadrant turn over the whole grid
                if (ry == 0) begin
                    if (rx == 1) begin
                        cx = n - 1 - cx;
                        cy = n - 1 - cy;
                    end
                    tmp = cx;
                    cx  = cy;
                    cy  = tmp;
                end
            end
            res.pidx = d[IDX_W-1:0];
        end else begin
            t  = 32'(idx) & ((1 << (2 * k)) - 1);
            cx = 0;
            cy = 0;
            for (s = 1; s < n; s = s << 1) begin
                rx = (t >> 1) & 1;
                ry = (t ^ rx) & 1;
                // turn within the sub-square built so far
                if (ry == 0) begin
                    if (rx == 1) begin
                        cx = s - 1 - cx;
                        cy = s - 1 - cy;
                    end
                    tmp = cx;
                    cx  = cy;
                    cy  = tmp;
                end
                cx = cx + s * rx;
                cy = cy + s * ry;
                t  = t >> 2;
            end
            res.px = cx[XY_W-1:0];
            res.py = cy[XY_W-1:0];
        end
        return res;
    endfunction

    // lets the pipe drain, then writes the order register
    task automatic set_curve_order(input logic [ORDER_W-1:0] order);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= order;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_order    = order;
    endtask

    task automatic send_request(input t_req req, input logic [XY_W-1:0] x,
                                input logic [XY_W-1:0] y, input logic [IDX_W-1:0] idx,
                                input bit typed, input t_curve_result typed_want);
        int unsigned gap;
        gap = sender_burst ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {idx, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(typed ? typed_want
                                         : hilbert_predict(cur_order, req, x, y, idx));
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // output checker and watchdog count
    always @(posedge i_clk) begin
        t_curve_result want;
        t_curve_result got;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                got.px   = m_axis_tdata[XY_W-1:0];
                got.py   = m_axis_tdata[2*XY_W-1:XY_W];
                got.pidx = m_axis_tdata[DATA_W-1:2*XY_W];
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result beat, expected none, actual x=%0d y=%0d index=%0d",
                             $time, got.px, got.py, got.pidx);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("out_x", 32'(want.px), 32'(got.px));
                    compare_field("out_y", 32'(want.py), 32'(got.py));
                    compare_field("out_index", 32'(want.pidx), 32'(got.pidx));
                end
            end
        end
    end

    // result receiver: random stalls, idle-free stretches, one long hold-off
    initial begin
        int unsigned beats;
        int unsigned stall;
        bit          held;
        beats = 0;
        held  = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!held && beats >= 300) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            stall = ((beats % 256) < 64) ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            beats++;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("tb_hilbert_curve_index_convert failed");
        $finish;
    end

    initial begin
        int unsigned   k;
        int unsigned   xy_mask;
        int unsigned   idx_mask;
        t_curve_result want;
        t_req          req;
        logic [XY_W-1:0]  x, y;
        logic [IDX_W-1:0] idx;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].order != cur_order)
                set_curve_order(directed_rows[i].order);
            want.px   = directed_rows[i].want_x;
            want.py   = directed_rows[i].want_y;
            want.pidx = directed_rows[i].want_idx;
            send_request(directed_rows[i].req, directed_rows[i].x, directed_rows[i].y,
                         directed_rows[i].idx, directed_rows[i].typed, want);
        end

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            if (ph == 0)
                set_curve_order(4'd8);
            else if (ph == 1)
                set_curve_order(4'd1);
            else
                set_curve_order(ORDER_W'($urandom_range(0, 15)));
            sender_burst = ($urandom_range(0, 2) == 0);
            k        = grid_order(cur_order);
            xy_mask  = (1 << k) - 1;
            idx_mask = (1 << (2 * k)) - 1;
            for (int n = 0; n < PHASE_BEATS; n++) begin
                req = t_req'($urandom_range(0, 1));
                x   = XY_W'($urandom);
                y   = XY_W'($urandom);
                idx = IDX_W'($urandom);
                // mostly on-grid values; the rest wrap
                if ($urandom_range(0, 3) != 0) begin
                    if (req == REQ_XY_TO_IDX) begin
                        x = x & XY_W'(xy_mask);
                        y = y & XY_W'(xy_mask);
                    end else begin
                        idx = idx & IDX_W'(idx_mask);
                    end
                end
                send_request(req, x, y, idx, PREDICT, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_hilbert_curve_index_convert passed");
        else
            $display("tb_hilbert_curve_index_convert failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/hcic_pkg.sv
hdl/hcic_level.sv
hdl/hilbert_curve_index_convert.sv
bench/tb_hilbert_curve_index_convert.sv
